// ----- hw/rtl/rcpd_pkg.sv -----
// ----------------------------------------------------------------------------
// rcpd_pkg
// shared types, constants and pulse arithmetic for the rc pulse decoder
// ----------------------------------------------------------------------------
package rcpd_pkg;

   localparam int NUM_LINES = 8;
   localparam int PPM_SLOTS = 8;
   localparam int SLOT_W    = 3;
   localparam int CH_W      = 3;
   localparam int CAP_W     = 16;
   localparam int MS_W      = 32;
   localparam int ADDR_W    = 5;
   localparam int DATA_W    = 32;

   localparam logic [SLOT_W:0] SLOT_COUNT = PPM_SLOTS[SLOT_W:0];

   typedef enum logic [2:0] {
      REG_PPM_MODE        = 3'd0,
      REG_PPM_ACTIVE_LOW  = 3'd1,
      REG_TIMER_PERIOD    = 3'd2,
      REG_SYNC_TICKS      = 3'd3,
      REG_ALIVE_THRESHOLD = 3'd4
   } reg_index_type;

   typedef enum logic {
      OP_EDGE = 1'b0,
      OP_READ = 1'b1
   } opcode_type;

   typedef struct packed {
      logic             ppm_mode;
      logic             ppm_active_low;
      logic [CAP_W-1:0] timer_period;
      logic [CAP_W-1:0] sync_ticks;
      logic [MS_W-1:0]  alive_threshold;
   } cfg_type;

   typedef struct packed {
      opcode_type       opcode;
      logic [CH_W-1:0]  channel;
      logic             level;
      logic [CAP_W-1:0] capture_time;
      logic [MS_W-1:0]  now_ms;
   } req_type;

   typedef logic [NUM_LINES-1:0][CAP_W-1:0] widths_type;

   // pulse width with wrap at the timer period
   function automatic logic [CAP_W-1:0] span(input logic [CAP_W-1:0] start,
                                             input logic [CAP_W-1:0] stop,
                                             input logic [CAP_W-1:0] period);
      logic [CAP_W-1:0] wrapped;
      wrapped = period - start + stop;
      if (stop > start) begin
         return stop - start;
      end
      return wrapped;
   endfunction

   // strictly older than the threshold counts as silence
   function automatic logic silent(input logic [MS_W-1:0] now,
                                   input logic [MS_W-1:0] last,
                                   input logic [MS_W-1:0] threshold);
      logic [MS_W-1:0] age;
      age = now - last;
      return age > threshold;
   endfunction

endpackage

// ----- hw/rtl/rc_pwm_ppm_capture_decoder.sv -----
// ----------------------------------------------------------------------------
// rc_pwm_ppm_capture_decoder
// rc pulse decoder: turns captured edge stamps into pwm or ppm channel widths
// ----------------------------------------------------------------------------
//
//   port group   direction   handshake                 carries
//   req_*        in          req_valid / req_ready     edge event or read request
//   rsp_*        out         rsp_valid / rsp_ready     eight channel widths per read
//   p*           in/out      psel, penable, pwrite     mode, polarity, period, sync, alive regs
//
// one request per cycle sustained while no read waits; a taken request sits in the
// input register while the decode stage updates all channel state
// a read moves from the input register into the response register, which raises
// rsp_valid; the response register holds it until rsp_ready takes it
// edge events give no response; a read waits only while the response register
// is full and not taken, and req_ready drops then; reset sets all but payload regs
//
module rc_pwm_ppm_capture_decoder (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_opcode,
   input  logic [rcpd_pkg::CH_W-1:0]          req_channel,
   input  logic                               req_level,
   input  logic [rcpd_pkg::CAP_W-1:0]         req_capture_time,
   input  logic [rcpd_pkg::MS_W-1:0]          req_now_ms,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [rcpd_pkg::CAP_W-1:0]         rsp_width_ch0,
   output logic [rcpd_pkg::CAP_W-1:0]         rsp_width_ch1,
   output logic [rcpd_pkg::CAP_W-1:0]         rsp_width_ch2,
   output logic [rcpd_pkg::CAP_W-1:0]         rsp_width_ch3,
   output logic [rcpd_pkg::CAP_W-1:0]         rsp_width_ch4,
   output logic [rcpd_pkg::CAP_W-1:0]         rsp_width_ch5,
   output logic [rcpd_pkg::CAP_W-1:0]         rsp_width_ch6,
   output logic [rcpd_pkg::CAP_W-1:0]         rsp_width_ch7,
   // configuration port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [rcpd_pkg::ADDR_W-1:0]        paddr,
   input  logic [rcpd_pkg::DATA_W-1:0]        pwdata,
   output logic [rcpd_pkg::DATA_W-1:0]        prdata,
   output logic                               pready
);

   rcpd_pkg::cfg_type     cfg;
   rcpd_pkg::req_type     req_item;
   rcpd_pkg::widths_type  widths_calc;

   // input register
   logic                  in_valid_ff;
   logic                  in_valid_in;
   rcpd_pkg::req_type     in_item_ff;

   // response register
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rcpd_pkg::widths_type  rsp_widths_ff;

   logic                  req_fire;
   logic                  stage_advance;
   logic                  stage_fire;
   logic                  rsp_load;

   assign pready = 1'b1;

   assign req_item.opcode       = rcpd_pkg::opcode_type'(req_opcode);
   assign req_item.channel      = req_channel;
   assign req_item.level        = req_level;
   assign req_item.capture_time = req_capture_time;
   assign req_item.now_ms       = req_now_ms;

   // edges always move on; a read needs room in the response register
   assign stage_advance = (in_item_ff.opcode == rcpd_pkg::OP_EDGE) || !rsp_valid_ff || rsp_ready;
   assign stage_fire    = in_valid_ff && stage_advance;
   assign rsp_load      = stage_fire && (in_item_ff.opcode == rcpd_pkg::OP_READ);
   assign req_ready     = !in_valid_ff || stage_advance;
   assign req_fire      = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (stage_fire) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= req_item;
      end
      if (rsp_load) begin
         rsp_widths_ff <= widths_calc;
      end
   end

   rcpd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   rcpd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (stage_fire),
      .item       (in_item_ff),
      .cfg        (cfg),
      .widths     (widths_calc)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_width_ch0 = rsp_widths_ff[0];
   assign rsp_width_ch1 = rsp_widths_ff[1];
   assign rsp_width_ch2 = rsp_widths_ff[2];
   assign rsp_width_ch3 = rsp_widths_ff[3];
   assign rsp_width_ch4 = rsp_widths_ff[4];
   assign rsp_width_ch5 = rsp_widths_ff[5];
   assign rsp_width_ch6 = rsp_widths_ff[6];
   assign rsp_width_ch7 = rsp_widths_ff[7];

endmodule

// ----- hw/rtl/rcpd_csr.sv -----
// ----------------------------------------------------------------------------
// rcpd_csr
// apb-style configuration registers of the rc pulse decoder
// ----------------------------------------------------------------------------
module rcpd_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [rcpd_pkg::ADDR_W-1:0]    paddr,
   input  logic [rcpd_pkg::DATA_W-1:0]    pwdata,
   output logic [rcpd_pkg::DATA_W-1:0]    prdata,
   output rcpd_pkg::cfg_type              cfg
);

   rcpd_pkg::cfg_type       cfg_ff;
   rcpd_pkg::cfg_type       cfg_in;
   rcpd_pkg::reg_index_type reg_sel;
   logic                    wr_en;

   assign reg_sel = rcpd_pkg::reg_index_type'(paddr[rcpd_pkg::ADDR_W-1:2]);
   assign wr_en   = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            rcpd_pkg::REG_PPM_MODE:        cfg_in.ppm_mode        = pwdata[0];
            rcpd_pkg::REG_PPM_ACTIVE_LOW:  cfg_in.ppm_active_low  = pwdata[0];
            rcpd_pkg::REG_TIMER_PERIOD:    cfg_in.timer_period    = pwdata[rcpd_pkg::CAP_W-1:0];
            rcpd_pkg::REG_SYNC_TICKS:      cfg_in.sync_ticks      = pwdata[rcpd_pkg::CAP_W-1:0];
            rcpd_pkg::REG_ALIVE_THRESHOLD: cfg_in.alive_threshold = pwdata[rcpd_pkg::MS_W-1:0];
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         rcpd_pkg::REG_PPM_MODE:
            prdata = {{(rcpd_pkg::DATA_W-1){1'b0}}, cfg_ff.ppm_mode};
         rcpd_pkg::REG_PPM_ACTIVE_LOW:
            prdata = {{(rcpd_pkg::DATA_W-1){1'b0}}, cfg_ff.ppm_active_low};
         rcpd_pkg::REG_TIMER_PERIOD:
            prdata = {{(rcpd_pkg::DATA_W-rcpd_pkg::CAP_W){1'b0}}, cfg_ff.timer_period};
         rcpd_pkg::REG_SYNC_TICKS:
            prdata = {{(rcpd_pkg::DATA_W-rcpd_pkg::CAP_W){1'b0}}, cfg_ff.sync_ticks};
         rcpd_pkg::REG_ALIVE_THRESHOLD:
            prdata = cfg_ff.alive_threshold;
         default:
            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ppm_mode        <= 1'b0;
         cfg_ff.ppm_active_low  <= 1'b0;
         cfg_ff.timer_period    <= 16'd65535;
         cfg_ff.sync_ticks      <= 16'd4000;
         cfg_ff.alive_threshold <= 32'd100;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hw/rtl/rcpd_core.sv -----
// ----------------------------------------------------------------------------
// rcpd_core
// per-line stamp, width and liveness state with its update logic
// ----------------------------------------------------------------------------
module rcpd_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  rcpd_pkg::req_type    item,
   input  rcpd_pkg::cfg_type    cfg,
   output rcpd_pkg::widths_type widths
);

   logic [rcpd_pkg::CAP_W-1:0]  rise_ff  [rcpd_pkg::NUM_LINES];
   logic [rcpd_pkg::CAP_W-1:0]  rise_in  [rcpd_pkg::NUM_LINES];
   logic [rcpd_pkg::CAP_W-1:0]  fall_ff  [rcpd_pkg::NUM_LINES];
   logic [rcpd_pkg::CAP_W-1:0]  fall_in  [rcpd_pkg::NUM_LINES];
   logic [rcpd_pkg::CAP_W-1:0]  pw_ff    [rcpd_pkg::NUM_LINES];
   logic [rcpd_pkg::CAP_W-1:0]  pw_in    [rcpd_pkg::NUM_LINES];
   logic [rcpd_pkg::MS_W-1:0]   seen_ff  [rcpd_pkg::NUM_LINES];
   logic [rcpd_pkg::MS_W-1:0]   seen_in  [rcpd_pkg::NUM_LINES];
   logic [rcpd_pkg::NUM_LINES-1:0] fresh_ff;
   logic [rcpd_pkg::NUM_LINES-1:0] fresh_in;
   logic [rcpd_pkg::SLOT_W-1:0] slot_ff;
   logic [rcpd_pkg::SLOT_W-1:0] slot_in;
   logic [rcpd_pkg::MS_W-1:0]   line_seen_ff;
   logic [rcpd_pkg::MS_W-1:0]   line_seen_in;

   logic [rcpd_pkg::SLOT_W-1:0] slot_idx;
   logic [rcpd_pkg::SLOT_W-1:0] slot_next;
   logic [rcpd_pkg::CAP_W-1:0]  ppm_width;
   logic                        line_silent;
   logic [rcpd_pkg::NUM_LINES-1:0] line_dead;
   rcpd_pkg::widths_type        widths_calc;

   // out-of-range slot falls back to slot zero
   always_comb begin
      slot_idx  = ({1'b0, slot_ff} < rcpd_pkg::SLOT_COUNT) ? slot_ff : '0;
      slot_next = (({1'b0, slot_idx} + 1'b1) == rcpd_pkg::SLOT_COUNT) ? '0 : slot_idx + 1'b1;
      ppm_width = rcpd_pkg::span(rise_ff[slot_idx], item.capture_time, cfg.timer_period);
      line_silent = rcpd_pkg::silent(item.now_ms, line_seen_ff, cfg.alive_threshold);
   end

   // read view of all lines, including the zeroing and fresh-pair width
   always_comb begin
      for (int i = 0; i < rcpd_pkg::NUM_LINES; i++) begin
         line_dead[i] = rcpd_pkg::silent(item.now_ms, seen_ff[i], cfg.alive_threshold);
         if (cfg.ppm_mode) begin
            widths_calc[i] = (i < rcpd_pkg::PPM_SLOTS && !line_silent) ? pw_ff[i] : '0;
         end else if (line_dead[i]) begin
            widths_calc[i] = '0;
         end else if (fresh_ff[i]) begin
            widths_calc[i] = rcpd_pkg::span(rise_ff[i], fall_ff[i], cfg.timer_period);
         end else begin
            widths_calc[i] = pw_ff[i];
         end
      end
   end

   always_comb begin
      rise_in      = rise_ff;
      fall_in      = fall_ff;
      pw_in        = pw_ff;
      seen_in      = seen_ff;
      fresh_in     = fresh_ff;
      slot_in      = slot_ff;
      line_seen_in = line_seen_ff;
      if (item_valid) begin
         case (item.opcode)
            rcpd_pkg::OP_EDGE: begin
               if (cfg.ppm_mode) begin
                  if (item.level != cfg.ppm_active_low) begin
                     rise_in[slot_idx] = item.capture_time;
                  end else begin
                     fall_in[slot_idx] = item.capture_time;
                     line_seen_in      = item.now_ms;
                     // long pulse is the frame sync
                     if (ppm_width >= cfg.sync_ticks) begin
                        slot_in = '0;
                     end else begin
                        pw_in[slot_idx] = ppm_width;
                        slot_in         = slot_next;
                     end
                  end
               end else if (item.level) begin
                  rise_in[item.channel]  = item.capture_time;
                  fresh_in[item.channel] = 1'b0;
               end else begin
                  fall_in[item.channel]  = item.capture_time;
                  fresh_in[item.channel] = 1'b1;
                  seen_in[item.channel]  = item.now_ms;
               end
            end
            rcpd_pkg::OP_READ: begin
               for (int i = 0; i < rcpd_pkg::NUM_LINES; i++) begin
                  if (cfg.ppm_mode) begin
                     if (line_silent && i < rcpd_pkg::PPM_SLOTS) begin
                        pw_in[i] = '0;
                     end
                  end else begin
                     pw_in[i] = widths_calc[i];
                     if (!line_dead[i]) begin
                        fresh_in[i] = 1'b0;
                     end
                  end
               end
            end
            default: begin
               slot_in = slot_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rcpd_pkg::NUM_LINES; i++) begin
            rise_ff[i] <= '0;
            fall_ff[i] <= '0;
            pw_ff[i]   <= '0;
            seen_ff[i] <= '0;
         end
         fresh_ff     <= '0;
         slot_ff      <= '0;
         line_seen_ff <= '0;
      end else begin
         rise_ff      <= rise_in;
         fall_ff      <= fall_in;
         pw_ff        <= pw_in;
         seen_ff      <= seen_in;
         fresh_ff     <= fresh_in;
         slot_ff      <= slot_in;
         line_seen_ff <= line_seen_in;
      end
   end

   assign widths = widths_calc;

endmodule

// ----- hw/rtl/rcpd_checker.sv -----
// ----------------------------------------------------------------------------
// rcpd_checker
// port-level checks of the rc pulse decoder, bound to the top level
// ----------------------------------------------------------------------------
module rcpd_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [rcpd_pkg::CAP_W-1:0]         rsp_width_ch0,
   input logic [rcpd_pkg::CAP_W-1:0]         rsp_width_ch7,
   input logic                               pready
);

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_width_ch0) && $stable(rsp_width_ch7))
      else $error("stalled response changed");

   // an empty response register never blocks requests
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty response register");

   // with no request taken and rsp_ready held, the input and response registers drain
   assert property (@(posedge clock) disable iff (reset)
      (!(req_valid && req_ready) && rsp_ready) ##1 (!(req_valid && req_ready) && rsp_ready)
      |=> !rsp_valid)
      else $error("response appeared without a request");

   // nothing pending right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && pready)
      else $error("response valid after reset");

endmodule

bind rc_pwm_ppm_capture_decoder rcpd_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_width_ch0 (rsp_width_ch0),
   .rsp_width_ch7 (rsp_width_ch7),
   .pready        (pready)
);
